>>> src/row_pair_correlation_unit_defines.svh
// Assertion macros for the row pair correlation unit.
// Each macro expands to a labeled concurrent assertion on clk_i.
`ifndef ROW_PAIR_CORRELATION_UNIT_DEFINES_SVH
`define ROW_PAIR_CORRELATION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only outside reset.
`define RPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define RPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define RPC_ASSERT(lbl, prop, msg)
`define RPC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> src/rpc_pkg.sv
package rpc_pkg;

  // Operation codes of an input request.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration port layout and register indexes.
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT    = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLUMN_COUNT = 4'd1;

  // Result and iteration widths fixed by the Q2.30 output.
  localparam int CORR_BITS = 32;
  localparam int QBITS     = 63;
  localparam int ROOT_BITS = 32;
  localparam int RAD_BITS  = 2 * ROOT_BITS;
  localparam int SREM_BITS = ROOT_BITS + 2;
  localparam int SQ_STEPS  = ROOT_BITS;

  // Products formed by the serial multiplier, in the order they are issued.
  typedef enum logic [2:0] {
    MUL_NSXX = 3'd0,
    MUL_SXSX = 3'd1,
    MUL_NSYY = 3'd2,
    MUL_SYSY = 3'd3,
    MUL_NSXY = 3'd4,
    MUL_SXSY = 3'd5,
    MUL_VV   = 3'd6,
    MUL_MM   = 3'd7
  } mul_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    rd_en;
    logic    mul_start;
    logic    mul_step;
    mul_op_e mul_op;
    logic    div_init;
    logic    div_step;
    logic    sqrt_init;
    logic    sqrt_step;
    logic    out_load;
  } rpc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad;
    logic col_last;
    logic mul_last;
    logic div_last;
    logic sqrt_last;
    logic zero_var;
  } rpc_status_t;

endpackage

>>> src/rpc_ram.sv
module rpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/rpc_dpath.sv
module rpc_dpath #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rpc_pkg::rpc_cmd_t             cmd_i,
  output rpc_pkg::rpc_status_t          status_o,
  input  logic [6:0]                    row_count_i,
  input  logic [8:0]                    column_count_i,
  input  logic                          load_en_i,
  input  logic [5:0]                    row_a_i,
  input  logic [5:0]                    row_b_i,
  input  logic [7:0]                    column_i,
  input  logic signed [15:0]            sample_i,
  output logic signed [rpc_pkg::CORR_BITS-1:0] correlation_o,
  output logic                          result_status_o
);
  import rpc_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int CW  = $clog2(MAX_COLUMNS + 1);
  localparam int AW  = $clog2(MAX_ROWS * MAX_COLUMNS);
  localparam int SW  = SB + CW;
  localparam int QW  = 2 * SB + CW;
  localparam int VW  = 2 * SB + 2 * CW + 1;
  localparam int PW  = 2 * VW;
  localparam int ITW = $clog2(((VW > QBITS) ? VW : QBITS) + 1);

  function automatic logic [VW-1:0] abs_v(input logic signed [VW-1:0] v);
    abs_v = v[VW-1] ? -v : v;
  endfunction

  // Range checks on the incoming request.
  logic in_store;
  logic query_bad;
  always_comb begin
    int rows_eff;
    rows_eff  = (int'(row_count_i) > MAX_ROWS) ? MAX_ROWS : int'(row_count_i);
    in_store  = (int'(row_a_i) < MAX_ROWS) && (int'(column_i) < MAX_COLUMNS);
    query_bad = (int'(row_a_i) >= rows_eff) || (int'(row_b_i) >= rows_eff) ||
                (column_count_i == '0);
  end

  // Query registers captured at acceptance.
  logic [5:0]    ra_q, rb_q;
  logic [CW-1:0] n_q, k_q;
  logic          bad_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ra_q  <= row_a_i;
      rb_q  <= row_b_i;
      bad_q <= query_bad;
      n_q   <= (int'(column_count_i) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(column_count_i);
      k_q   <= '0;
    end else if (cmd_i.rd_en) begin
      k_q <= k_q + CW'(1);
    end
  end

  // Two copies of the sample store, so both rows are read together.
  logic [AW-1:0] waddr, xaddr, yaddr;
  logic [SB-1:0] wdata, xdata, ydata;
  logic          we;

  assign we    = load_en_i && in_store;
  assign waddr = AW'(AW'(row_a_i) * MAX_COLUMNS) + AW'(column_i);
  assign xaddr = AW'(AW'(ra_q) * MAX_COLUMNS) + AW'(k_q);
  assign yaddr = AW'(AW'(rb_q) * MAX_COLUMNS) + AW'(k_q);
  assign wdata = SB'(sample_i);

  rpc_ram #(.WIDTH(SB), .DEPTH(MAX_ROWS * MAX_COLUMNS)) u_x_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(xaddr),
    .rdata_o(xdata)
  );

  rpc_ram #(.WIDTH(SB), .DEPTH(MAX_ROWS * MAX_COLUMNS)) u_y_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(yaddr),
    .rdata_o(ydata)
  );

  // Running sums over the columns, one column per cycle.
  logic                 rd_valid_q;
  logic signed [SB-1:0] xs, ys;
  logic signed [2*SB-1:0] xx, yy, xy;
  logic signed [SW-1:0] sx_q, sy_q;
  logic signed [QW-1:0] sxx_q, syy_q, sxy_q;

  assign xs = xdata;
  assign ys = ydata;
  assign xx = xs * xs;
  assign yy = ys * ys;
  assign xy = xs * ys;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      syy_q <= '0;
      sxy_q <= '0;
    end else if (rd_valid_q) begin
      sx_q  <= sx_q + SW'(xs);
      sy_q  <= sy_q + SW'(ys);
      sxx_q <= sxx_q + QW'(xx);
      syy_q <= syy_q + QW'(yy);
      sxy_q <= sxy_q + QW'(xy);
    end
  end

  // Operand selection for the serial multiplier.
  logic signed [VW-1:0] vx_q, vy_q, num_q;
  logic signed [VW-1:0] opa, opb;
  logic signed [VW-1:0] n_e, sx_e, sy_e, sxx_e, syy_e, sxy_e;

  assign n_e   = VW'(n_q);
  assign sx_e  = VW'(sx_q);
  assign sy_e  = VW'(sy_q);
  assign sxx_e = VW'(sxx_q);
  assign syy_e = VW'(syy_q);
  assign sxy_e = VW'(sxy_q);

  always_comb begin
    case (cmd_i.mul_op)
      MUL_NSXX: begin opa = n_e;  opb = sxx_e; end
      MUL_SXSX: begin opa = sx_e; opb = sx_e;  end
      MUL_NSYY: begin opa = n_e;  opb = syy_e; end
      MUL_SYSY: begin opa = sy_e; opb = sy_e;  end
      MUL_NSXY: begin opa = n_e;  opb = sxy_e; end
      MUL_SXSY: begin opa = sx_e; opb = sy_e;  end
      MUL_VV:   begin opa = vx_q; opb = vy_q;  end
      default:  begin opa = num_q; opb = num_q; end
    endcase
  end

  // Shift-and-add multiplier, one multiplier bit per cycle.
  logic [PW-1:0]  mcand_q, prod_q, prod_nx, sprod, p_q, t_q;
  logic [VW-1:0]  mplier_q;
  logic           neg_q;
  logic [ITW-1:0] it_q;
  logic signed [VW-1:0] sp_v;

  assign prod_nx = prod_q + (mplier_q[0] ? mcand_q : '0);
  assign sprod   = neg_q ? -prod_nx : prod_nx;
  assign sp_v    = sprod[VW-1:0];

  // Restoring divider and digit-by-digit square root.
  logic [PW:0]           rem_q, rem_diff;
  logic                  rem_ge;
  logic [QBITS-1:0]      q_q;
  logic [RAD_BITS-1:0]   rad_q;
  logic [SREM_BITS-1:0]  srem_q, s_cur, s_trial;
  logic [ROOT_BITS-1:0]  root_q;
  logic                  s_ge;

  assign rem_ge   = rem_q >= {1'b0, p_q};
  assign rem_diff = rem_ge ? (rem_q - {1'b0, p_q}) : rem_q;
  assign s_cur    = {srem_q[SREM_BITS-3:0], rad_q[RAD_BITS-1 -: 2]};
  assign s_trial  = {root_q, 2'b01};
  assign s_ge     = s_cur >= s_trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_q <= '0;
    end else if (cmd_i.mul_start || cmd_i.div_init || cmd_i.sqrt_init) begin
      it_q <= '0;
    end else if (cmd_i.mul_step || cmd_i.div_step || cmd_i.sqrt_step) begin
      it_q <= it_q + ITW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      mcand_q  <= PW'(abs_v(opa));
      mplier_q <= abs_v(opb);
      prod_q   <= '0;
      neg_q    <= opa[VW-1] ^ opb[VW-1];
    end else if (cmd_i.mul_step) begin
      prod_q   <= prod_nx;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
      if (status_o.mul_last) begin
        case (cmd_i.mul_op)
          MUL_NSXX: vx_q  <= sp_v;
          MUL_SXSX: vx_q  <= vx_q - sp_v;
          MUL_NSYY: vy_q  <= sp_v;
          MUL_SYSY: vy_q  <= vy_q - sp_v;
          MUL_NSXY: num_q <= sp_v;
          MUL_SXSY: num_q <= num_q - sp_v;
          MUL_VV:   p_q   <= prod_nx;
          default:  t_q   <= prod_nx;
        endcase
      end
    end

    // Quotient of 2^62 * num^2 / (Vx * Vy), one bit per cycle.
    if (cmd_i.div_init) begin
      rem_q <= {1'b0, t_q};
    end else if (cmd_i.div_step) begin
      rem_q <= {rem_diff[PW-1:0], 1'b0};
      q_q   <= {q_q[QBITS-2:0], rem_ge};
    end

    // Integer square root of the quotient, two radicand bits per cycle.
    if (cmd_i.sqrt_init) begin
      rad_q  <= RAD_BITS'(q_q);
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= rad_q << 2;
      srem_q <= s_ge ? (s_cur - s_trial) : s_cur;
      root_q <= {root_q[ROOT_BITS-2:0], s_ge};
    end
  end

  // Round the root to Q2.30 and apply the sign of the numerator; a bad query or zero variance gives zero.
  logic [ROOT_BITS:0]          rnd;
  logic [CORR_BITS-1:0]        mag_r;
  logic signed [CORR_BITS-1:0] corr_q, corr_d;
  logic                        zero_var, stat_q;

  assign rnd      = {1'b0, root_q} + (ROOT_BITS + 1)'(1);
  assign mag_r    = CORR_BITS'(rnd[ROOT_BITS:1]);
  assign zero_var = (vx_q == '0) || (vy_q == '0);
  assign corr_d   = (bad_q || zero_var) ? '0 : (num_q[VW-1] ? -mag_r : mag_r);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      corr_q <= corr_d;
      stat_q <= bad_q;
    end
  end

  assign correlation_o   = corr_q;
  assign result_status_o = stat_q;

  assign status_o.bad       = query_bad;
  assign status_o.col_last  = (k_q == (n_q - CW'(1)));
  assign status_o.mul_last  = (it_q == ITW'(VW - 1));
  assign status_o.div_last  = (it_q == ITW'(QBITS - 1));
  assign status_o.sqrt_last = (it_q == ITW'(SQ_STEPS - 1));
  assign status_o.zero_var  = zero_var;

endmodule

>>> src/rpc_ctrl.sv
module rpc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_accept_i,
  input  logic                 operation_i,
  input  logic                 out_free_i,
  input  rpc_pkg::rpc_status_t status_i,
  output rpc_pkg::rpc_cmd_t    cmd_o,
  output logic                 in_ready_o
);
  import rpc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_ACC    = 10'b00_0000_0010,
    S_DRAIN  = 10'b00_0000_0100,
    S_MUL_GO = 10'b00_0000_1000,
    S_MUL    = 10'b00_0001_0000,
    S_DIV_GO = 10'b00_0010_0000,
    S_DIV    = 10'b00_0100_0000,
    S_SQ_GO  = 10'b00_1000_0000,
    S_SQ     = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  state_e  state_q, state_d;
  mul_op_e mul_op_q, mul_op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mul_op_q <= MUL_NSXX;
    end else begin
      state_q  <= state_d;
      mul_op_q <= mul_op_d;
    end
  end

  // Sequence: walk the columns, eight products (six on zero variance), divide, square root, deliver.
  always_comb begin
    state_d    = state_q;
    mul_op_d   = mul_op_q;
    cmd_o      = '0;
    cmd_o.mul_op = mul_op_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_accept_i && (operation_i == OP_QUERY)) begin
          cmd_o.capture = 1'b1;
          state_d = status_i.bad ? S_DONE : S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.col_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        mul_op_d = MUL_NSXX;
        state_d  = S_MUL_GO;
      end
      S_MUL_GO: begin
        cmd_o.mul_start = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.mul_last) begin
          if (mul_op_q == MUL_MM) begin
            state_d = S_DIV_GO;
          end else if ((mul_op_q == MUL_SXSY) && status_i.zero_var) begin
            state_d = S_DONE;
          end else begin
            mul_op_d = mul_op_e'(mul_op_q + 3'd1);
            state_d  = S_MUL_GO;
          end
        end
      end
      S_DIV_GO: begin
        cmd_o.div_init = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_SQ_GO;
        end
      end
      S_SQ_GO: begin
        cmd_o.sqrt_init = 1'b1;
        state_d = S_SQ;
      end
      S_SQ: begin
        cmd_o.sqrt_step = 1'b1;
        if (status_i.sqrt_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/row_pair_correlation_unit.sv
// A load request gives no result; loads are taken whenever the unit is idle.
// A query keeps the unit busy until its result is loaded into the output register; zero variance
// skips the divider and square root, and a bad row goes straight to the result.
// The query time is set by the one-bit-per-cycle multiplier, divider and square root.
// Reset sets row_count to 64 and column_count to 256; the sample store is undefined until written.
`include "row_pair_correlation_unit_defines.svh"

module row_pair_correlation_unit #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 operation_i,
  input  logic [5:0]                           row_a_i,
  input  logic [5:0]                           row_b_i,
  input  logic [7:0]                           column_i,
  input  logic signed [15:0]                   sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [rpc_pkg::CORR_BITS-1:0] correlation_o,
  output logic                                 status_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rpc_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [rpc_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);
  import rpc_pkg::*;

  logic [6:0]  row_count_q;
  logic [8:0]  column_count_q;
  logic        in_accept;
  logic        out_valid_q;
  rpc_cmd_t    cmd;
  rpc_status_t status;

  // Configuration registers; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= 7'd64;
      column_count_q <= 9'd256;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ROW_COUNT:    row_count_q    <= cfg_data_i[6:0];
        REG_COLUMN_COUNT: column_count_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  assign in_accept = in_valid_i && in_ready_o;

  rpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_accept_i(in_accept),
    .operation_i(operation_i),
    .out_free_i (!out_valid_q || out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  rpc_dpath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLUMNS(MAX_COLUMNS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .row_count_i    (row_count_q),
    .column_count_i (column_count_q),
    .load_en_i      (in_accept && (operation_i == OP_LOAD)),
    .row_a_i        (row_a_i),
    .row_b_i        (row_b_i),
    .column_i       (column_i),
    .sample_i       (sample_i),
    .correlation_o  (correlation_o),
    .result_status_o(status_o)
  );

  // Output register: the next request is taken while a result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  `RPC_ASSERT(a_bad_gives_zero, out_valid_o && status_o |-> correlation_o == '0, "out-of-range query with nonzero correlation")
  `RPC_ASSERT(a_corr_range, out_valid_o |-> (correlation_o <= 32'sd1073741824) && (correlation_o >= -32'sd1073741824), "correlation outside unit range")
  `RPC_ASSERT(a_query_busy, in_valid_i && in_ready_o && (operation_i == OP_QUERY) |=> !in_ready_o, "query did not occupy the unit")
  `RPC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

>>> tb/row_pair_correlation_unit_tb.sv
`timescale 1ns / 100ps

module row_pair_correlation_unit_tb;
  import rpc_pkg::*;

  localparam int ROWS = 64;
  localparam int COLS = 256;
  localparam int QUERY_CYCLES = 900;
  localparam longint CYCLE_LIMIT = 64'd12_000_000;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 4'd9;

  // One input request as the driver presents it.
  typedef struct {
    logic              op;
    logic [5:0]        ra;
    logic [5:0]        rb;
    logic [7:0]        col;
    logic signed [15:0] smp;
    bit                hold;
  } request_t;

  typedef struct {
    logic signed [31:0] corr;
    logic               status;
  } corr_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic operation_i = OP_LOAD;
  logic [5:0] row_a_i = '0;
  logic [5:0] row_b_i = '0;
  logic [7:0] column_i = '0;
  logic signed [15:0] sample_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [CORR_BITS-1:0] correlation_o;
  logic status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;

  request_t pending_q[$];
  corr_result_t corr_expect_q[$];

  // Mirror of the sample store as loads are accepted, and as planned by the generator.
  logic signed [15:0] store_mirror[ROWS][COLS];
  logic signed [15:0] planned[ROWS][COLS];
  bit written[ROWS][COLS];
  int row_limit = 64;
  int col_limit = 256;
  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;
  int n_loads = 0;
  int n_queries = 0;
  int n_bad = 0;
  longint cycles = 0;

  row_pair_correlation_unit i_dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Exact correlation in Q2.30, rounded to nearest with ties away from zero.
  function automatic logic [31:0] pearson_q30(int ra, int rb, int n);
    longint sx, sy, sxx, syy, sxy, x, y, lo, hi, mid;
    logic signed [255:0] wn, tsx, tsy, tsxx, tsyy, tsxy, vx, vy, num;
    logic [255:0] mag, prod, target, d;
    bit neg;
    sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
    for (int k = 0; k < n; k++) begin
      x = store_mirror[ra][k];
      y = store_mirror[rb][k];
      sx += x; sy += y; sxx += x * x; syy += y * y; sxy += x * y;
    end
    wn = n; tsx = sx; tsy = sy; tsxx = sxx; tsyy = syy; tsxy = sxy;
    vx = wn * tsxx - tsx * tsx;
    vy = wn * tsyy - tsy * tsy;
    if (vx == 0 || vy == 0) return '0;
    num = wn * tsxy - tsx * tsy;
    neg = num < 0;
    mag = neg ? -num : num;
    prod = vx * vy;
    target = (mag * mag) << 62;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      d = 2 * mid - 1;
      if (d * d * prod <= target) lo = mid;
      else hi = mid - 1;
    end
    return neg ? 32'(-lo) : 32'(lo);
  endfunction

  // Applies one accepted request to the mirror and queues its result, if any.
  task automatic predict_request(request_t r);
    corr_result_t e;
    if (r.op == OP_LOAD) begin
      store_mirror[r.ra][r.col] = r.smp;
      n_loads++;
      return;
    end
    n_queries++;
    if (r.ra >= row_limit || r.rb >= row_limit || col_limit == 0) begin
      e.corr = '0;
      e.status = 1'b1;
      n_bad++;
    end else begin
      e.corr = pearson_q30(r.ra, r.rb, col_limit);
      e.status = 1'b0;
    end
    corr_expect_q.push_back(e);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Request driver: fed from the pending queue, idles at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_request('{operation_i, row_a_i, row_b_i, column_i, sample_i, 1'b0});
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_q.size() != 0 && !(pending_q[0].hold && corr_expect_q.size() != 0)
            && $urandom_range(99) >= send_idle) begin
          operation_i <= pending_q[0].op;
          row_a_i <= pending_q[0].ra;
          row_b_i <= pending_q[0].rb;
          column_i <= pending_q[0].col;
          sample_i <= pending_q[0].smp;
          in_valid_i <= 1'b1;
          void'(pending_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    corr_result_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (corr_expect_q.size() == 0) begin
          report_mismatch("unexpected result", correlation_o, '0);
        end else begin
          e = corr_expect_q.pop_front();
          if (correlation_o !== e.corr) report_mismatch("correlation", correlation_o, e.corr);
          if (status_o !== e.status) report_mismatch("status", status_o, e.status);
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("row_pair_correlation_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic push_load(int r, int c, logic signed [15:0] s);
    pending_q.push_back('{OP_LOAD, 6'(r), 6'($urandom_range(63)), 8'(c), s, 1'b0});
    planned[r][c] = s;
    written[r][c] = 1'b1;
  endtask

  task automatic push_query(int ra, int rb, bit hold);
    pending_q.push_back('{OP_QUERY, 6'(ra), 6'(rb), 8'($urandom_range(255)), 16'($urandom),
                          hold});
  endtask

  // Loads every column in use that the row still lacks, so no query reads an empty entry.
  task automatic fill_row(int r, int n, int src, int mode);
    logic signed [15:0] s;
    for (int c = 0; c < n; c++) begin
      if (!written[r][c]) begin
        case (mode)
          1: s = planned[src][c];
          2: s = -planned[src][c];
          3: s = planned[src][c] + 16'($signed($urandom_range(40)) - 20);
          default: s = 16'($urandom);
        endcase
        push_load(r, c, s);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid_i || corr_expect_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_ROW_COUNT) row_limit = (data[6:0] > ROWS) ? ROWS : int'(data[6:0]);
    else if (idx == REG_COLUMN_COUNT) col_limit = (data[8:0] > COLS) ? COLS : int'(data[8:0]);
  endtask

  // One random phase under a fixed setting.
  task automatic run_phase(int n_items);
    int base, ra, rb, mode, src, pool[4];
    base = pending_q.size();
    pool = '{0, 1, 2, 63};
    while (pending_q.size() - base < n_items) begin
      if ($urandom_range(99) < 55) begin
        if (col_limit > 64) begin
          ra = pool[$urandom_range(3)];
          rb = pool[$urandom_range(3)];
        end else if (row_limit > 0 && $urandom_range(99) < 85) begin
          ra = $urandom_range(row_limit - 1);
          rb = $urandom_range(row_limit - 1);
        end else begin
          ra = $urandom_range(63);
          rb = $urandom_range(63);
        end
        if (ra < row_limit && rb < row_limit && col_limit > 0) begin
          fill_row(ra, col_limit, 0, 0);
          mode = $urandom_range(5);
          src = ra;
          if (mode > 3 || rb == ra) mode = 0;
          fill_row(rb, col_limit, src, mode);
        end
        push_query(ra, rb, pending_q.size() == base);
      end else begin
        ra = $urandom_range(63);
        if (col_limit > 0 && $urandom_range(99) < 70) rb = $urandom_range(col_limit - 1);
        else rb = $urandom_range(255);
        push_load(ra, rb, 16'($urandom));
      end
    end
    wait_drained();
  endtask

  typedef struct {
    logic [15:0] rows;
    logic [15:0] cols;
    int          n;
  } phase_t;

  initial begin
    phase_t ph[9];
    rst_ni <= 1'b0;
    ph = '{'{16'hFF8A, 16'h0008, 200}, '{16'hFFC0, 16'hFF00, 80}, '{16'h0001, 16'h0001, 100},
           '{16'h007F, 16'h01FF, 60}, '{16'h0000, 16'h0005, 40}, '{16'h0003, 16'h0000, 40},
           '{16'h0040, 16'h0002, 150}, '{16'h0014, 16'h0020, 150}, '{16'h0040, 16'h0040, 150}};
    send_idle = 8;
    recv_idle = 82;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part: sample extremes, negated and constant rows, self and zero-variance queries.
    write_reg(REG_ROW_COUNT, 16'd64);
    write_reg(REG_COLUMN_COUNT, 16'd4);
    write_reg(REG_UNUSED, 16'hFFFF);
    push_load(0, 0, 16'sd32767);
    push_load(0, 1, -16'sd32768);
    push_load(0, 2, 16'sd0);
    push_load(0, 3, 16'sd1);
    push_load(63, 0, -16'sd32767);
    push_load(63, 1, 16'sd32767);
    push_load(63, 2, 16'sd0);
    push_load(63, 3, -16'sd1);
    for (int c = 0; c < 4; c++) push_load(5, c, 16'sd7);
    push_load(2, 255, -16'sd1);
    push_load(62, 128, 16'sh5555);
    push_query(0, 63, 1'b1);
    push_query(63, 0, 1'b0);
    push_query(0, 0, 1'b0);
    push_query(5, 5, 1'b0);
    push_query(0, 5, 1'b0);
    push_query(63, 63, 1'b0);
    wait_drained();

    // Random phases through a range of settings.
    for (int p = 0; p < 9; p++) begin
      if (p == 4) begin
        send_idle = 82;
        recv_idle = 8;
      end else if (p == 7) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_reg(REG_ROW_COUNT, ph[p].rows);
      write_reg(REG_COLUMN_COUNT, ph[p].cols);
      run_phase(ph[p].n);
    end

    wait_drained();
    repeat (QUERY_CYCLES) @(posedge clk_i);
    if (corr_expect_q.size() != 0) report_mismatch("results never arrived",
                                                   corr_expect_q.size(), 0);
    $display("Covered %0d loads and %0d queries (%0d out of range) over ten register settings.",
             n_loads, n_queries, n_bad);
    $display("Mismatches: %0d.", errors);
    if (errors == 0) begin
      $display("row_pair_correlation_unit_tb: done, clean");
    end else begin
      $display("row_pair_correlation_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
